FILE: design/hgd_pkg.sv
// Shared constants, types and a helper function of the hex grid diffusion stencil.
`timescale 1ns / 1ps

package hgd_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int VALUE_BITS = 16;
  localparam int FRAC_BITS  = 8;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CNT_W  = 11;
  localparam int IDX_W  = 10;
  localparam int MODE_W = 3;

  // Compare width that holds positions and counts plus one carry bit
  localparam int POS_MAX_W = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int CMP_W     = ((POS_MAX_W > CNT_W) ? POS_MAX_W : CNT_W) + 1;

  localparam int APB_W  = 32;
  localparam int ADDR_W = 4;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int CRED_W     = FIFO_CNT_W + 1;

  // Arithmetic widths: 12*VMAX fits SUM_W, the quotient by four fits QW
  localparam int SUM_W    = VALUE_BITS + 4;
  localparam int QW       = VALUE_BITS + 2;
  localparam int RECIP_SH = QW + 1;
  localparam int PROD_W   = QW + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'(((64'd1 << RECIP_SH) / 3) + 1);

  localparam logic [VALUE_BITS-1:0] VMAX    = {VALUE_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0] ONE_VAL =
    (FRAC_BITS < VALUE_BITS) ? VALUE_BITS'(64'd1 << FRAC_BITS) : {VALUE_BITS{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_COPY        = 3'd0,
    MODE_GATED_FLOOR = 3'd1,
    MODE_GATED_BIN   = 3'd2,
    MODE_BIN         = 3'd3,
    MODE_HOLE_HOLD   = 3'd4,
    MODE_WALL        = 3'd5,
    MODE_PLAIN       = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_ROWS = 2'd1,
    REG_COLS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                  hole;
    logic                  flag;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  typedef struct packed {
    entry_t older;
    entry_t newer;
  } row_pair_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  row_count;
    logic [CNT_W-1:0]  col_count;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] out_value;
    logic                  out_flag;
    logic [IDX_W-1:0]      out_row;
    logic [IDX_W-1:0]      out_col;
    logic                  last;
  } result_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input int maxv);
    int c;
    c = int'(v);
    if (c < 3) c = 3;
    if (c > maxv) c = maxv;
    return CNT_W'(c);
  endfunction

endpackage

FILE: design/hgd_if.sv
// Valid/ready channel interfaces for cell items and result items.
`timescale 1ns / 1ps

interface hgd_cell_if import hgd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] cell_value;
  logic                  cell_flag;
  logic                  cell_hole;

  modport source (output valid, output cell_value, output cell_flag, output cell_hole,
                  input ready);
  modport sink (input valid, input cell_value, input cell_flag, input cell_hole,
                output ready);
endinterface

interface hgd_result_if import hgd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] out_value;
  logic                  out_flag;
  logic [IDX_W-1:0]      out_row;
  logic [IDX_W-1:0]      out_col;
  logic                  last;

  modport source (output valid, output out_value, output out_flag, output out_row,
                  output out_col, output last, input ready);
  modport sink (input valid, input out_value, input out_flag, input out_row,
                input out_col, input last, output ready);
endinterface

FILE: design/hgd_cfg.sv
// APB register block: mode, row count and column count.
`timescale 1ns / 1ps

module hgd_cfg import hgd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= MODE_COPY;
      cfg.row_count <= clamp_count(CNT_W'(1024), MAX_ROWS);
      cfg.col_count <= clamp_count(CNT_W'(1024), MAX_COLS);
    end else if (wr) begin
      case (idx)
        REG_MODE: cfg.mode      <= pwdata[MODE_W-1:0];
        REG_ROWS: cfg.row_count <= clamp_count(pwdata[CNT_W-1:0], MAX_ROWS);
        REG_COLS: cfg.col_count <= clamp_count(pwdata[CNT_W-1:0], MAX_COLS);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE: prdata = APB_W'(cfg.mode);
      REG_ROWS: prdata = APB_W'(cfg.row_count);
      REG_COLS: prdata = APB_W'(cfg.col_count);
      default:  prdata = '0;
    endcase
  end

endmodule

FILE: design/hgd_row_store.sv
// Row store memory: older and newer row entry per column, registered read.
`timescale 1ns / 1ps

module hgd_row_store import hgd_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output row_pair_t        rd_data,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  row_pair_t        wr_data
);

  row_pair_t mem [MAX_COLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/hgd_window.sv
// Column window, hex neighbor selection and weighted neighbor sum.
`timescale 1ns / 1ps

module hgd_window import hgd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             v1,
  input  tag_t             tag1,
  input  entry_t           cur1,
  input  row_pair_t        rows1,
  output logic             v2,
  output logic [SUM_W-1:0] t2,
  output tag_t             tag2,
  output entry_t           centre2,
  output logic             nbz2
);

  entry_t           col1 [3];  // column c-1, rows top..bottom
  entry_t           col0 [3];  // column c-2
  entry_t           nb   [6];
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] cv;
  logic             nbz;

  always_comb begin
    nb[0] = rows1.newer;
    nb[1] = col1[2];
    nb[2] = col0[1];
    nb[3] = col1[0];
    // even centre column leans to the lower row, odd to the upper row
    if (!tag1.col[0]) begin
      nb[4] = cur1;
      nb[5] = col0[2];
    end else begin
      nb[4] = rows1.older;
      nb[5] = col0[0];
    end
    cv  = SUM_W'(col1[1].value);
    sum = (cv << 2) + (cv << 1);
    nbz = 1'b0;
    for (int k = 0; k < 6; k++) begin
      sum = sum + SUM_W'(nb[k].value);
      nbz = nbz | ~nb[k].flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        col1[k] <= '0;
        col0[k] <= '0;
      end
    end else begin
      v2 <= v1;
      if (v1) begin
        col0    <= col1;
        col1[0] <= rows1.older;
        col1[1] <= rows1.newer;
        col1[2] <= cur1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      t2      <= sum;
      tag2    <= tag1;
      centre2 <= col1[1];
      nbz2    <= nbz;
    end
  end

endmodule

FILE: design/hgd_calc.sv
// Divide by twelve through a reciprocal product, then apply the mode rule.
`timescale 1ns / 1ps

module hgd_calc import hgd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [MODE_W-1:0] mode,
  input  logic              v2,
  input  logic [SUM_W-1:0]  t2,
  input  tag_t              tag2,
  input  entry_t            centre2,
  input  logic              nbz2,
  output logic              done,
  output logic              push,
  output result_t           res
);

  logic                  v3;
  logic [PROD_W-1:0]     prod3;
  tag_t                  tag3;
  entry_t                centre3;
  logic                  nbz3;
  logic [QW-1:0]         q;
  logic [VALUE_BITS-1:0] d;
  logic [VALUE_BITS-1:0] x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  // (S + 6V) / 12 = ((S + 6V) >> 2) / 3
  always_ff @(posedge clk) begin
    if (v2) begin
      prod3   <= PROD_W'(t2[SUM_W-1:2]) * PROD_W'(RECIP);
      tag3    <= tag2;
      centre3 <= centre2;
      nbz3    <= nbz2;
    end
  end

  always_comb begin
    q = prod3[PROD_W-1:RECIP_SH];
    d = (q > QW'(VMAX)) ? VMAX : q[VALUE_BITS-1:0];
    x = centre3.flag ? '0 : d;
    res.out_value = centre3.value;
    res.out_flag  = centre3.flag;
    unique case (mode)
      MODE_GATED_FLOOR: res.out_value = (x < ONE_VAL) ? '0 : x;
      MODE_GATED_BIN:   res.out_value = (x != '0) ? ONE_VAL : '0;
      MODE_BIN:         res.out_value = (d != '0) ? ONE_VAL : '0;
      MODE_HOLE_HOLD:   res.out_value = centre3.hole ? centre3.value : d;
      MODE_WALL:        res.out_flag  = centre3.flag & nbz3;
      MODE_PLAIN:       res.out_value = d;
      default: ;
    endcase
    res.out_row = tag3.row;
    res.out_col = tag3.col;
    res.last    = tag3.last;
  end

  assign done = v3;
  assign push = v3 && tag3.emit;

endmodule

FILE: design/hgd_out_fifo.sv
// Result queue that decouples the stencil pipeline from the output channel.
`timescale 1ns / 1ps

module hgd_out_fifo import hgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               din,
  output logic [FIFO_CNT_W-1:0] count,
  hgd_result_if.source          results
);

  result_t               q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;
  result_t               head;

  assign pop  = results.valid && results.ready;
  assign head = q[rd_ptr];

  assign results.valid     = (count != '0);
  assign results.out_value = head.out_value;
  assign results.out_flag  = head.out_flag;
  assign results.out_row   = head.out_row;
  assign results.out_col   = head.out_col;
  assign results.last      = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= din;
    end
  end

endmodule

FILE: design/hex_grid_diffusion_stencil_core.sv
// Top level of the hexagonal six-neighbor diffusion stencil.
`timescale 1ns / 1ps

// Cells of a padded tile enter in raster order on the cells channel, one item
// per clock when both sides keep up. For every interior cell one result item
// leaves on the results channel: the new value (centre halved plus the six
// hex neighbors over twelve, shaped by the mode register), the flag, the
// interior row and column, and last on the final interior cell. The two
// previous rows live in one row store memory (one entry per column holding the
// older and newer row), read when a cell is accepted and written back in the
// next cycle with the row shifted; a three-column window of registers gives
// the remaining neighbors. A result is registered in v1, v2 and v3 before it
// reaches the output queue. The sustained rate is one cell per cycle, set by the
// single read-modify-write of the row store per cell; an eight-entry result
// queue absorbs output stalls and the input is held off only when that queue
// and the pipeline together could overflow. The row store needs no clearing
// pass after reset: results use only entries the tile wrote. Write mode,
// row_count and col_count over APB only while the block is idle.

module hex_grid_diffusion_stencil_core import hgd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  hgd_cell_if.sink          cells,
  hgd_result_if.source      results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  cfg_t cfg;

  // raster position of the next cell
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos_next;
  logic [COL_W-1:0] col_pos_next;

  logic             acc;
  logic [CMP_W-1:0] r_ext, c_ext, rc_ext, cc_ext;
  logic             emit0, last0;
  tag_t             tag0;
  entry_t           cur0;

  // stage 1: row store data arrives
  logic             v1;
  tag_t             tag1;
  entry_t           cur1;
  logic [COL_W-1:0] c1;
  row_pair_t        rows1;
  row_pair_t        wb1;

  // stage 2 and beyond
  logic             v2;
  logic [SUM_W-1:0] t2;
  tag_t             tag2;
  entry_t           centre2;
  logic             nbz2;

  logic                  done;
  logic                  push;
  result_t               res;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [1:0]            inflight;
  logic [CRED_W-1:0]     credit_used;

  hgd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Hold off input when every item in the pipeline plus those queued could
  // fill the result queue.
  assign credit_used = CRED_W'(fifo_count) + CRED_W'(inflight);
  assign cells.ready = (credit_used < CRED_W'(FIFO_DEPTH));
  assign acc         = cells.valid && cells.ready;

  assign r_ext  = CMP_W'(row_pos);
  assign c_ext  = CMP_W'(col_pos);
  assign rc_ext = CMP_W'(cfg.row_count);
  assign cc_ext = CMP_W'(cfg.col_count);

  // Emit once the 3x3 neighborhood around (r-1, c-1) is complete.
  assign emit0 = (r_ext >= CMP_W'(2)) && (c_ext >= CMP_W'(2)) &&
                 (r_ext < rc_ext) && (c_ext < cc_ext);
  assign last0 = (r_ext == rc_ext - CMP_W'(1)) && (c_ext == cc_ext - CMP_W'(1));

  always_comb begin
    tag0.emit = emit0;
    tag0.last = last0;
    tag0.row  = IDX_W'(r_ext - CMP_W'(1));
    tag0.col  = IDX_W'(c_ext - CMP_W'(1));
    cur0.value = cells.cell_value;
    cur0.flag  = cells.cell_flag;
    cur0.hole  = cells.cell_hole;
  end

  // Advance the raster position; wrap to the next row, or to row zero.
  always_comb begin
    if (c_ext + CMP_W'(1) >= cc_ext) begin
      col_pos_next = '0;
      row_pos_next = (r_ext + CMP_W'(1) >= rc_ext) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos_next = col_pos + 1'b1;
      row_pos_next = row_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos  <= '0;
      col_pos  <= '0;
      v1       <= 1'b0;
      inflight <= '0;
    end else begin
      v1       <= acc;
      inflight <= inflight + 2'(acc) - 2'(done);
      if (acc) begin
        row_pos <= row_pos_next;
        col_pos <= col_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      tag1 <= tag0;
      cur1 <= cur0;
      c1   <= col_pos;
    end
  end

  // Read on accept, write back the shifted column pair in the next cycle. The
  // same column comes back no sooner than three items later, so the write
  // always lands before the next read of that entry.
  assign wb1.older = rows1.newer;
  assign wb1.newer = cur1;

  hgd_row_store u_row_store (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (col_pos),
    .rd_data (rows1),
    .wr_en   (v1),
    .wr_addr (c1),
    .wr_data (wb1)
  );

  hgd_window u_window (
    .clk     (clk),
    .rst     (rst),
    .v1      (v1),
    .tag1    (tag1),
    .cur1    (cur1),
    .rows1   (rows1),
    .v2      (v2),
    .t2      (t2),
    .tag2    (tag2),
    .centre2 (centre2),
    .nbz2    (nbz2)
  );

  hgd_calc u_calc (
    .clk     (clk),
    .rst     (rst),
    .mode    (cfg.mode),
    .v2      (v2),
    .t2      (t2),
    .tag2    (tag2),
    .centre2 (centre2),
    .nbz2    (nbz2),
    .done    (done),
    .push    (push),
    .res     (res)
  );

  hgd_out_fifo u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .din     (res),
    .count   (fifo_count),
    .results (results)
  );

  // The write-back of one item never targets the column read by the next.
  a_no_store_collision: assert property (@(posedge clk) disable iff (rst)
    (v1 && acc) |-> (col_pos != c1))
    else $error("row store read and write-back hit the same column");

  // Every emitting cell is pushed into the result queue.
  a_emit_latency: assert property (@(posedge clk) disable iff (rst)
    (acc && emit0) |-> ##3 push)
    else $error("emitting cell did not reach the result queue");

  // The input throttle keeps the result queue from overflowing.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

endmodule

FILE: verif/hex_grid_diffusion_stencil_core_test.sv
// Self-checking testbench of the hexagonal six-neighbor diffusion stencil core.
`timescale 1ns / 1ps

// Stream whole padded tiles of cells into the core, raster order, and predict
// every interior result from a software copy of the row stores and window.
// Start with a short table of hand-built 3x3 tiles whose results are typed in.
// Then sweep all eight mode codes on small random tiles. Then write counts past
// the top and read back the clamped maximum, and run one tall and one wide tile
// whose short side is reached through an out-of-range write that must clamp.
// Finish with a stretch free of idling. Write registers only between whole
// tiles, once every due result has drained.
module hex_grid_diffusion_stencil_core_test;
  import hgd_pkg::*;

  localparam int          DRAIN_CYCLES  = 12;    // latency margin before a write
  localparam int          IDLE_LIMIT    = 2000;  // cycles without any item moving
  localparam int          HOLD_CYCLES   = 200;   // long receiver hold-off
  localparam int unsigned UNIT          = 1 << FRAC_BITS;  // 1.0 in Q8.8
  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;  // unused code, acts as copy

  localparam result_t NO_RESULT = '0;

  // One row of the directed table: a cell, the mode to set before it when it
  // opens a tile, and optionally the result typed in by hand.
  typedef struct packed {
    logic              first;
    logic [MODE_W-1:0] mode;
    entry_t            stim;
    logic              typed;
    result_t           want;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  hgd_cell_if   cells_ch ();
  hgd_result_if results_ch ();

  hex_grid_diffusion_stencil_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .cells   (cells_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Software copy of the stencil state
  entry_t            stencil_older [MAX_COLS];
  entry_t            stencil_newer [MAX_COLS];
  entry_t            stencil_win [6];
  int unsigned       stencil_row;
  int unsigned       stencil_col;
  logic [MODE_W-1:0] stencil_mode;
  int unsigned       stencil_rows;
  int unsigned       stencil_cols;

  result_t    results_due [$];
  result_t    due_head;
  int         bad_count = 0;
  int         idle_cycles = 0;
  logic       hold_req = 1'b0;
  logic       calm = 1'b0;
  probe_row_t probe_rows [27];

  function automatic void note_mismatch(string msg);
    bad_count++;
    if (bad_count <= 10) $display("MISMATCH %s", msg);
  endfunction

  function automatic void clear_stencil();
    int k;
    for (k = 0; k < MAX_COLS; k++) begin
      stencil_older[k] = '0;
      stencil_newer[k] = '0;
    end
    for (k = 0; k < 6; k++) stencil_win[k] = '0;
    stencil_row  = 0;
    stencil_col  = 0;
    stencil_mode = MODE_COPY;
    stencil_rows = MAX_ROWS;
    stencil_cols = MAX_COLS;
  endfunction

  // Keep only the low count bits, then pull the count into [3, limit].
  function automatic int unsigned bound_count(logic [APB_W-1:0] value, int unsigned limit);
    int unsigned n;
    n = value[CNT_W-1:0];
    if (n < 3) n = 3;
    if (n > limit) n = limit;
    return n;
  endfunction

  function automatic void set_stencil_reg(reg_idx_t idx, logic [APB_W-1:0] value);
    case (idx)
      REG_MODE: stencil_mode = value[MODE_W-1:0];
      REG_ROWS: stencil_rows = bound_count(value, MAX_ROWS);
      REG_COLS: stencil_cols = bound_count(value, MAX_COLS);
      default: ;
    endcase
  endfunction

  // Advance the stencil by one cell; return 1 with the result when the cell
  // completes the 3x3 neighborhood of an interior cell.
  function automatic bit hex_stencil_step(input entry_t cur, output result_t res);
    entry_t            g [3][3];
    entry_t            nb [6];
    int unsigned       r, c, i, j, total, diff, x;
    logic [VALUE_BITS-1:0] v;
    logic              f, open_side;
    int                k;
    bit                emit;
    r = stencil_row;
    c = stencil_col;
    res = NO_RESULT;
    // Read both rows above at this column, then shift the column down a row.
    g[0][2] = stencil_older[c];
    g[1][2] = stencil_newer[c];
    g[2][2] = cur;
    stencil_older[c] = stencil_newer[c];
    stencil_newer[c] = cur;
    for (k = 0; k < 3; k++) begin
      g[k][1] = stencil_win[k];
      g[k][0] = stencil_win[3 + k];
      stencil_win[3 + k] = stencil_win[k];
      stencil_win[k] = g[k][2];
    end
    emit = (r >= 2 && c >= 2 && r < stencil_rows && c < stencil_cols);
    if (c + 1 >= stencil_cols) begin
      stencil_col = 0;
      stencil_row = (r + 1 >= stencil_rows) ? 0 : r + 1;
    end else begin
      stencil_col = c + 1;
    end
    if (!emit) return 1'b0;

    i = r - 1;
    j = c - 1;
    v = g[1][1].value;
    f = g[1][1].flag;
    // Odd columns sit half a cell higher, so they lean on the row above.
    if (j[0]) begin
      nb[0] = g[0][2]; nb[1] = g[1][2]; nb[2] = g[2][1];
      nb[3] = g[1][0]; nb[4] = g[0][0]; nb[5] = g[0][1];
    end else begin
      nb[0] = g[1][2]; nb[1] = g[2][2]; nb[2] = g[2][1];
      nb[3] = g[2][0]; nb[4] = g[1][0]; nb[5] = g[0][1];
    end
    total = 6 * v;
    open_side = 1'b0;
    for (k = 0; k < 6; k++) begin
      total += nb[k].value;
      if (!nb[k].flag) open_side = 1'b1;
    end
    // Half the centre plus a twelfth of the ring, truncated once.
    diff = total / 12;
    if (diff > VMAX) diff = VMAX;

    res.out_value = v;
    res.out_flag  = f;
    case (stencil_mode)
      MODE_GATED_FLOOR: begin
        x = f ? 0 : diff;
        res.out_value = (x < UNIT) ? '0 : VALUE_BITS'(x);
      end
      MODE_GATED_BIN: begin
        x = f ? 0 : diff;
        res.out_value = (x > 0) ? VALUE_BITS'(UNIT) : '0;
      end
      MODE_BIN:       res.out_value = (diff > 0) ? VALUE_BITS'(UNIT) : '0;
      MODE_HOLE_HOLD: res.out_value = g[1][1].hole ? v : VALUE_BITS'(diff);
      MODE_WALL:      res.out_flag  = f & open_side;
      MODE_PLAIN:     res.out_value = VALUE_BITS'(diff);
      default: ;  // copy, and the spare code behaves the same
    endcase
    res.out_row = IDX_W'(i);
    res.out_col = IDX_W'(j);
    res.last    = (i == stencil_rows - 2 && j == stencil_cols - 2);
    return 1'b1;
  endfunction

  function automatic entry_t random_cell();
    entry_t e;
    case ($urandom_range(0, 5))
      0:       e.value = '0;
      1:       e.value = VMAX;
      2:       e.value = VALUE_BITS'($urandom_range(0, 300));  // around 1.0
      default: e.value = VALUE_BITS'($urandom);
    endcase
    // Lean the flag toward set so wall detection sees both outcomes.
    e.flag = ($urandom_range(0, 3) != 0);
    e.hole = 1'($urandom_range(0, 1));
    return e;
  endfunction

  // APB transfers: setup, access until pready, then drop select and move on.
  task automatic apb_write(reg_idx_t idx, logic [APB_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    set_stencil_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(reg_idx_t idx, logic [APB_W-1:0] want);
    logic [APB_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(4 * int'(idx));
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want) note_mismatch($sformatf("register %0d read %h, want %h", idx, got, want));
  endtask

  // Offer one cell, maybe after an idle burst; on acceptance predict it.
  task automatic send_cell(entry_t e, int gap_pct, logic typed, result_t typed_res);
    result_t guess;
    if (!calm && $urandom_range(1, 100) <= gap_pct) begin
      cells_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cells_ch.valid      <= 1'b1;
    cells_ch.cell_value <= e.value;
    cells_ch.cell_flag  <= e.flag;
    cells_ch.cell_hole  <= e.hole;
    do @(posedge clk); while (!cells_ch.ready);
    if (hex_stencil_step(e, guess)) results_due.push_back(typed ? typed_res : guess);
  endtask

  // Drop valid and let every due result arrive before touching registers.
  task automatic wait_idle();
    cells_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Set up a tile shape and mode, then stream whole random tiles.
  task automatic run_phase(logic [MODE_W-1:0] mode, logic [APB_W-1:0] rows_w,
                           logic [APB_W-1:0] cols_w, int min_cells, int gap_pct,
                           bit long_stall);
    int sent;
    int r, c;
    sent = 0;
    wait_idle();
    apb_write(REG_MODE, APB_W'(mode));
    apb_write(REG_ROWS, rows_w);
    apb_write(REG_COLS, cols_w);
    if (long_stall) hold_req <= 1'b1;
    while (sent < min_cells) begin
      for (r = 0; r < int'(stencil_rows); r++) begin
        for (c = 0; c < int'(stencil_cols); c++) begin
          send_cell(random_cell(), gap_pct, 1'b0, NO_RESULT);
        end
      end
      sent += stencil_rows * stencil_cols;
    end
  endtask

  // Receiver: bursts of ready and of stall, one long hold-off on request,
  // and ready held high once the calm stretch starts.
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    results_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm || $urandom_range(0, 2) != 0) begin
        results_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        results_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  end

  // Compare each result item with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (results_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result row %0d col %0d value %h",
                                results_ch.out_row, results_ch.out_col,
                                results_ch.out_value));
      end else begin
        due_head = results_due.pop_front();
        if (results_ch.out_value !== due_head.out_value ||
            results_ch.out_flag  !== due_head.out_flag  ||
            results_ch.out_row   !== due_head.out_row   ||
            results_ch.out_col   !== due_head.out_col   ||
            results_ch.last      !== due_head.last) begin
          note_mismatch($sformatf(
            "want v=%h f=%b r=%0d c=%0d l=%b got v=%h f=%b r=%0d c=%0d l=%b",
            due_head.out_value, due_head.out_flag, due_head.out_row,
            due_head.out_col, due_head.last, results_ch.out_value,
            results_ch.out_flag, results_ch.out_row, results_ch.out_col,
            results_ch.last));
        end
      end
    end
  end

  // Watchdog: end the run when no item moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (cells_ch.valid && cells_ch.ready) ||
        (results_ch.valid && results_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int p, n, gap;
    // Three hand-built 3x3 tiles: saturated ring, all zero, and a wall test
    // on an odd column where the flag-clear cells below the centre must be
    // ignored while the clear corner above counts.
    probe_rows = '{
      '{1'b1, MODE_PLAIN, '{1'b1, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
      '{1'b0, MODE_PLAIN, '{1'b1, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
      '{1'b0, MODE_PLAIN, '{1'b1, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
      '{1'b0, MODE_PLAIN, '{1'b1, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
      '{1'b0, MODE_PLAIN, '{1'b1, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
      '{1'b0, MODE_PLAIN, '{1'b1, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
      '{1'b0, MODE_PLAIN, '{1'b1, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
      '{1'b0, MODE_PLAIN, '{1'b1, 1'b1, 16'hFFFF}, 1'b0, NO_RESULT},
      '{1'b0, MODE_PLAIN, '{1'b1, 1'b1, 16'hFFFF}, 1'b1,
        '{16'hFFFF, 1'b1, 10'd1, 10'd1, 1'b1}},
      '{1'b1, MODE_BIN, '{1'b0, 1'b0, 16'h0000}, 1'b0, NO_RESULT},
      '{1'b0, MODE_BIN, '{1'b0, 1'b0, 16'h0000}, 1'b0, NO_RESULT},
      '{1'b0, MODE_BIN, '{1'b0, 1'b0, 16'h0000}, 1'b0, NO_RESULT},
      '{1'b0, MODE_BIN, '{1'b0, 1'b0, 16'h0000}, 1'b0, NO_RESULT},
      '{1'b0, MODE_BIN, '{1'b0, 1'b0, 16'h0000}, 1'b0, NO_RESULT},
      '{1'b0, MODE_BIN, '{1'b0, 1'b0, 16'h0000}, 1'b0, NO_RESULT},
      '{1'b0, MODE_BIN, '{1'b0, 1'b0, 16'h0000}, 1'b0, NO_RESULT},
      '{1'b0, MODE_BIN, '{1'b0, 1'b0, 16'h0000}, 1'b0, NO_RESULT},
      '{1'b0, MODE_BIN, '{1'b0, 1'b0, 16'h0000}, 1'b1,
        '{16'h0000, 1'b0, 10'd1, 10'd1, 1'b1}},
      '{1'b1, MODE_WALL, '{1'b0, 1'b0, 16'h0040}, 1'b0, NO_RESULT},
      '{1'b0, MODE_WALL, '{1'b0, 1'b1, 16'h1234}, 1'b0, NO_RESULT},
      '{1'b0, MODE_WALL, '{1'b1, 1'b1, 16'h00FF}, 1'b0, NO_RESULT},
      '{1'b0, MODE_WALL, '{1'b0, 1'b1, 16'h0100}, 1'b0, NO_RESULT},
      '{1'b0, MODE_WALL, '{1'b1, 1'b1, 16'h0180}, 1'b0, NO_RESULT},
      '{1'b0, MODE_WALL, '{1'b0, 1'b1, 16'hABCD}, 1'b0, NO_RESULT},
      '{1'b0, MODE_WALL, '{1'b1, 1'b0, 16'h8000}, 1'b0, NO_RESULT},
      '{1'b0, MODE_WALL, '{1'b0, 1'b1, 16'h7FFF}, 1'b0, NO_RESULT},
      '{1'b0, MODE_WALL, '{1'b1, 1'b0, 16'hFFFE}, 1'b1,
        '{16'h0180, 1'b1, 10'd1, 10'd1, 1'b1}}
    };

    // Hold every input at a known value through reset.
    rst                 = 1'b1;
    cells_ch.valid      = 1'b0;
    cells_ch.cell_value = '0;
    cells_ch.cell_flag  = 1'b0;
    cells_ch.cell_hole  = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    clear_stencil();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values read back before anything is written.
    check_reg(REG_MODE, APB_W'(MODE_COPY));
    check_reg(REG_ROWS, APB_W'(MAX_ROWS));
    check_reg(REG_COLS, APB_W'(MAX_COLS));

    // Directed tiles, smallest legal shape.
    apb_write(REG_ROWS, 32'd3);
    apb_write(REG_COLS, 32'd3);
    for (p = 0; p < 27; p++) begin
      if (probe_rows[p].first) begin
        wait_idle();
        apb_write(REG_MODE, APB_W'(probe_rows[p].mode));
      end
      send_cell(probe_rows[p].stim, 20, probe_rows[p].typed, probe_rows[p].want);
    end

    // Sweep all eight mode codes on small random tiles, with gaps dense,
    // sparse or absent from phase to phase.
    for (p = 0; p < 8; p++) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      n = (p == 7) ? 3 : $urandom_range(3, 8);
      run_phase(MODE_W'(p % 8), APB_W'(n), APB_W'($urandom_range(3, 12)), 48, gap, 1'b0);
    end

    // Counts written past the top clamp down to the largest tile.
    wait_idle();
    apb_write(REG_ROWS, 32'd1500);
    apb_write(REG_COLS, 32'd2047);
    check_reg(REG_ROWS, APB_W'(MAX_ROWS));
    check_reg(REG_COLS, APB_W'(MAX_COLS));

    // Tall tile: column count clamped up to three.
    run_phase(MODE_W'($urandom_range(0, 7)), 32'd30, 32'd2, 1, 15, 1'b0);
    // Wide tile: row count clamped up from zero; the receiver holds off long
    // at the start so the core fills and stalls.
    run_phase(MODE_SPARE, 32'd0, 32'd50, 1, 0, 1'b1);

    // Final stretch with no idling on either side.
    calm <= 1'b1;
    run_phase(MODE_W'($urandom_range(0, 7)), 32'd5, 32'd7, 60, 0, 1'b0);

    wait_idle();
    if (bad_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
